>>> rtl/core/htsed_pkg.sv
// ---------------------------------------------------------------------------
// htsed_pkg
// Shared types and constants for the tag stripper and entity decoder.
// ---------------------------------------------------------------------------
package htsed_pkg;

    localparam int WINDOW_BYTES = 10;
    localparam int WIN_IDX_W    = $clog2(WINDOW_BYTES);
    localparam int WIN_CNT_W    = $clog2(WINDOW_BYTES + 1);
    localparam int NUM_ENT      = 13;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_QM   = 8'h3F;
    localparam logic [7:0] CH_DOT  = 8'h2E;

    // Entity patterns, first byte at the low end, padded with zeros.
    typedef logic [7:0] pat_t [0:6];

    typedef struct packed {
        logic [7:0] rep;
        logic [1:0] reps;
        logic [2:0] len;
    } ent_info_t;

    function automatic logic [7:0] ent_byte(input int e, input int k);
        string s;
        s = "";
        case (e)
            0:  s = "&amp;";
            1:  s = "&lt;";
            2:  s = "&gt;";
            3:  s = "&quot;";
            4:  s = "&apos;";
            5:  s = "&nbsp;";
            6:  s = "&#8211;";
            7:  s = "&#8212;";
            8:  s = "&#8216;";
            9:  s = "&#8217;";
            10: s = "&#8220;";
            11: s = "&#8221;";
            default: s = "&#8230;";
        endcase
        if (k < s.len())
            return s[k];
        return 8'h00;
    endfunction

    function automatic ent_info_t ent_info(input int e);
        ent_info_t r;
        r.reps = 2'd1;
        case (e)
            0:  begin r.rep = 8'h26; r.len = 3'd5; end
            1:  begin r.rep = 8'h3C; r.len = 3'd4; end
            2:  begin r.rep = 8'h3E; r.len = 3'd4; end
            3:  begin r.rep = 8'h22; r.len = 3'd6; end
            4:  begin r.rep = 8'h27; r.len = 3'd6; end
            5:  begin r.rep = 8'h20; r.len = 3'd6; end
            6:  begin r.rep = 8'h2D; r.len = 3'd7; end
            7:  begin r.rep = 8'h2D; r.len = 3'd7; end
            8:  begin r.rep = 8'h27; r.len = 3'd7; end
            9:  begin r.rep = 8'h27; r.len = 3'd7; end
            10: begin r.rep = 8'h22; r.len = 3'd7; end
            11: begin r.rep = 8'h22; r.len = 3'd7; end
            default: begin r.rep = CH_DOT; r.len = 3'd7; r.reps = 2'd3; end
        endcase
        return r;
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load_in;     // capture the input byte
        logic             feed;        // offer the held byte to the selected pass
        logic             pass_sel;    // 0 = first pass, 1 = second pass
        logic             final_mode;  // resolve even if the window is short
        logic             step;        // do one drain step on the selected pass
        logic             clear;       // end of string: clear the selected pass
        logic             bypass_step; // emit one raw byte from the second window
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             can_step;    // a drain step would emit a byte
        logic             win1_empty;
        logic             win0_empty;
        logic             emit_busy;   // output register full and not being taken
        logic             in_last;
    } dp_stat_t;

endpackage

>>> rtl/core/htsed_pass.sv
// ---------------------------------------------------------------------------
// htsed_pass
// One strip-and-decode pass: tag flag, look-ahead window and resolve logic.
// Each step emits at most one byte.
// ---------------------------------------------------------------------------
module htsed_pass
    import htsed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       feed,
    input  logic [7:0] feed_byte,
    input  logic       step,
    input  logic       final_mode,
    input  logic       clear,
    input  logic       bypass,
    output logic       can_step,
    output logic       empty,
    output logic [7:0] emit_byte
);

    logic [7:0]           win_reg [0:WINDOW_BYTES-1];
    logic [WIN_CNT_W-1:0] fill_reg;
    logic                 tag_reg;
    logic [1:0]           rep_left_reg;   // pending dots after the ellipsis
    logic [WIN_CNT_W-1:0] drop_n;
    logic [7:0]           out_b;
    logic                 m_ent;
    logic                 m_num;
    ent_info_t            info;
    logic [WIN_CNT_W-1:0] semi_k;
    logic                 hit;

    always_comb
    begin
        m_ent  = 1'b0;
        info   = ent_info(0);
        m_num  = 1'b0;
        semi_k = '0;
        for (int e = NUM_ENT - 1; e >= 0; e--)
        begin
            hit = (WIN_CNT_W'(ent_info(e).len) <= fill_reg);
            for (int k = 0; k < 7; k++)
                if (k < int'(ent_info(e).len) && win_reg[k] != ent_byte(e, k))
                    hit = 1'b0;
            if (hit)
            begin
                m_ent = 1'b1;
                info  = ent_info(e);
            end
        end
        for (int k = WINDOW_BYTES - 1; k >= 1; k--)
            if (WIN_CNT_W'(k) < fill_reg && win_reg[k] == CH_SEMI)
            begin
                m_num  = 1'b1;
                semi_k = WIN_CNT_W'(k);
            end
        if (!(fill_reg >= WIN_CNT_W'(2) && win_reg[1] == CH_HASH))
            m_num = 1'b0;
        hit = 1'b0;
    end

    always_comb
    begin
        drop_n = WIN_CNT_W'(1);
        out_b  = win_reg[0];
        if (rep_left_reg != 2'd0)
        begin
            out_b  = CH_DOT;
            drop_n = '0;
        end
        else if (bypass || win_reg[0] != CH_AMP)
        begin
            drop_n = WIN_CNT_W'(1);
        end
        else if (m_ent)
        begin
            out_b  = info.rep;
            drop_n = WIN_CNT_W'(info.len);
        end
        else if (m_num)
        begin
            out_b  = CH_QM;
            drop_n = semi_k + WIN_CNT_W'(1);
        end
    end

    assign emit_byte = out_b;
    assign empty     = (fill_reg == '0) && (rep_left_reg == 2'd0);
    assign can_step  = (rep_left_reg != 2'd0) ||
                       ((fill_reg != '0) && (bypass || win_reg[0] != CH_AMP ||
                        final_mode || fill_reg == WIN_CNT_W'(WINDOW_BYTES)));

    always_ff @(posedge clk)
    begin
        if (step && rep_left_reg == 2'd0)
            for (int i = 0; i < WINDOW_BYTES; i++)
                if (i + int'(drop_n) < WINDOW_BYTES)
                    win_reg[i] <= win_reg[i + int'(drop_n)];
        if (feed && !tag_reg && feed_byte != CH_LT && feed_byte != CH_GT &&
            fill_reg != WIN_CNT_W'(WINDOW_BYTES))
            win_reg[fill_reg[WIN_IDX_W-1:0]] <= feed_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            tag_reg      <= 1'b0;
            rep_left_reg <= 2'd0;
        end
        else if (clear)
        begin
            fill_reg     <= '0;
            tag_reg      <= 1'b0;
            rep_left_reg <= 2'd0;
        end
        else
        begin
            if (feed)
            begin
                if (feed_byte == CH_LT)
                    tag_reg <= 1'b1;
                else if (feed_byte == CH_GT)
                    tag_reg <= 1'b0;
                else if (!tag_reg && fill_reg != WIN_CNT_W'(WINDOW_BYTES))
                    fill_reg <= fill_reg + WIN_CNT_W'(1);
            end
            if (step)
            begin
                if (rep_left_reg != 2'd0)
                    rep_left_reg <= rep_left_reg - 2'd1;
                else
                begin
                    fill_reg <= fill_reg - drop_n;
                    if (!bypass && win_reg[0] == CH_AMP && m_ent)
                        rep_left_reg <= info.reps - 2'd1;
                end
            end
        end
    end

endmodule

>>> rtl/core/htsed_datapath.sv
// ---------------------------------------------------------------------------
// htsed_datapath
// Input holding register, both passes, a one-byte hold for the final byte of
// a string and the output register.
// ---------------------------------------------------------------------------
module htsed_datapath
    import htsed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  logic       emit_last,
    input  logic       emit_go,
    input  logic       second_pass,
    output dp_stat_t   stat,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       out_last
);

    logic [7:0] hold_reg;
    logic       last_reg;
    logic       ov_reg;
    logic [7:0] ob_reg;
    logic       oh_reg;
    logic       ol_reg;
    logic       pv_reg;     // a byte of the final input waits for out_last
    logic [7:0] pb_reg;
    logic       p0_can, p1_can, p0_empty, p1_empty;
    logic [7:0] p0_b, p1_b, new_b;
    logic       p0_step, p1_step, p1_feed, load_out;

    // A step of pass one feeds its byte straight into pass two when enabled.
    assign p0_step = cmd.step && !cmd.pass_sel;
    assign p1_step = (cmd.step && cmd.pass_sel) || cmd.bypass_step;
    assign p1_feed = p0_step && second_pass;

    htsed_pass u_p0 (
        .clk(clk), .rst_n(rst_n),
        .feed(cmd.feed && !cmd.pass_sel), .feed_byte(hold_reg),
        .step(p0_step), .final_mode(cmd.final_mode),
        .clear(cmd.clear && !cmd.pass_sel), .bypass(1'b0),
        .can_step(p0_can), .empty(p0_empty), .emit_byte(p0_b)
    );

    htsed_pass u_p1 (
        .clk(clk), .rst_n(rst_n),
        .feed(p1_feed), .feed_byte(p0_b),
        .step(p1_step), .final_mode(cmd.final_mode),
        .clear(cmd.clear && cmd.pass_sel), .bypass(cmd.bypass_step),
        .can_step(p1_can), .empty(p1_empty), .emit_byte(p1_b)
    );

    assign stat.can_step   = cmd.pass_sel ? p1_can : p0_can;
    assign stat.win1_empty = p1_empty;
    assign stat.win0_empty = p0_empty;
    assign stat.emit_busy  = ov_reg && !out_ready;
    assign stat.in_last    = last_reg;

    assign new_b = ((p1_step || !second_pass) && !(p0_step && !second_pass))
                   ? p1_b : p0_b;

    // While the final input byte is processed, each byte waits in the hold
    // until the next one comes, so that the very last one can carry out_last.
    assign load_out = emit_go && (emit_last || !last_reg || pv_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            hold_reg <= in_byte;
            last_reg <= in_last;
        end
        if (emit_go)
        begin
            if (emit_last)
            begin
                ob_reg <= pv_reg ? pb_reg : 8'h00;
                oh_reg <= pv_reg;
                ol_reg <= 1'b1;
            end
            else if (!last_reg)
            begin
                ob_reg <= new_b;
                oh_reg <= 1'b1;
                ol_reg <= 1'b0;
            end
            else
            begin
                if (pv_reg)
                begin
                    ob_reg <= pb_reg;
                    oh_reg <= 1'b1;
                    ol_reg <= 1'b0;
                end
                pb_reg <= new_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            pv_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            if (emit_go)
                pv_reg <= !emit_last && last_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign has_byte  = oh_reg;
    assign out_last  = ol_reg;

endmodule

>>> rtl/core/htsed_ctrl.sv
// ---------------------------------------------------------------------------
// htsed_ctrl
// Sequencer: takes one byte, drains both passes a byte at a time, and closes
// a string with its end marker.
// ---------------------------------------------------------------------------
module htsed_ctrl
    import htsed_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     second_pass,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     emit_go,
    output logic     emit_last
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_FEED   = 7'b0000010,
        S_DRAIN0 = 7'b0000100,
        S_DRAIN1 = 7'b0001000,
        S_BYPASS = 7'b0010000,
        S_FIN1   = 7'b0100000,
        S_END    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   can_emit;

    assign can_emit = !stat.emit_busy;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        emit_go    = 1'b0;
        emit_last  = 1'b0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_FEED;
                end
            end
            S_FEED:
            begin
                cmd.feed   = 1'b1;
                state_next = second_pass ? S_DRAIN0 : S_BYPASS;
            end
            S_BYPASS:
            begin
                // Second pass off: flush whatever it still holds, raw.
                if (stat.win1_empty)
                begin
                    cmd.pass_sel = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = S_DRAIN0;
                end
                else if (can_emit)
                begin
                    cmd.bypass_step = 1'b1;
                    emit_go         = 1'b1;
                end
            end
            S_DRAIN0:
            begin
                cmd.final_mode = stat.in_last;
                if (stat.can_step)
                begin
                    if (second_pass || can_emit)
                    begin
                        cmd.step = 1'b1;
                        if (!second_pass)
                            emit_go = 1'b1;
                        else
                            state_next = S_DRAIN1;
                    end
                end
                else
                begin
                    cmd.clear  = stat.in_last;
                    state_next = second_pass ? S_FIN1 :
                                 (stat.in_last ? S_END : S_IDLE);
                end
            end
            S_DRAIN1:
            begin
                // Pass one still has bytes to offer, so pass two drains
                // without resolving short windows.
                cmd.pass_sel = 1'b1;
                if (stat.can_step)
                begin
                    if (can_emit)
                    begin
                        cmd.step = 1'b1;
                        emit_go  = 1'b1;
                    end
                end
                else
                    state_next = S_DRAIN0;
            end
            S_FIN1:
            begin
                // Pass one is done; at the end of a string pass two resolves
                // everything it still holds.
                cmd.pass_sel   = 1'b1;
                cmd.final_mode = stat.in_last && stat.win0_empty;
                if (stat.can_step)
                begin
                    if (can_emit)
                    begin
                        cmd.step = 1'b1;
                        emit_go  = 1'b1;
                    end
                end
                else
                begin
                    cmd.clear  = stat.in_last;
                    state_next = stat.in_last ? S_END : S_IDLE;
                end
            end
            S_END:
            begin
                if (can_emit)
                begin
                    emit_go    = 1'b1;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/core/html_tag_strip_entity_decode.sv
// ---------------------------------------------------------------------------
// html_tag_strip_entity_decode
// Streaming markup-tag stripper and entity decoder with an optional second
// pass.
// ---------------------------------------------------------------------------
// Usage: text enters on the in_valid/in_ready channel one byte per
// transaction, with in_last on the final byte of a string. Cleaned bytes
// leave on the out_valid/out_ready channel, one byte per transaction with
// has_byte set; out_last marks the final result of a string, and a string
// that yields nothing closes with a bare end marker (has_byte 0).
// The second_pass register is written over cfg_valid/cfg_ready; cfg_ready
// is high only while the block is idle and ready for input.
// A new input byte is accepted only after every result of the last one is
// placed, so each byte out of pass one or pass two, and with the second pass
// off each byte still held by the second window, holds off the next input.
// The final byte of a string adds a closing result, which carries out_last
// on the last byte that is kept back until then.
// Reset clears both tag flags, both window fill counts and sets second_pass.
// When the receiver stalls the output register holds and the sequencer waits;
// no input is taken until all results of the current byte are placed.
// ---------------------------------------------------------------------------
module html_tag_strip_entity_decode
    import htsed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       out_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       second_pass
);

    logic     sp_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     emit_go, emit_last;

    // The register only changes between input bytes.
    assign cfg_ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sp_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            sp_reg <= second_pass;
    end

    htsed_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .second_pass(sp_reg), .stat(stat), .cmd(cmd),
        .emit_go(emit_go), .emit_last(emit_last)
    );

    htsed_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .cmd(cmd), .emit_last(emit_last),
        .emit_go(emit_go), .second_pass(sp_reg), .stat(stat),
        .in_byte(in_byte), .in_last(in_last),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_byte(out_byte), .has_byte(has_byte), .out_last(out_last)
    );

    // A new result is only placed when the output register is free.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte))
        else $error("output overwritten while stalled");

    // Input is never taken while results are still pending.
    a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !emit_go)
        else $error("input accepted while emitting");

    // A bare end marker always carries out_last.
    a_bare_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> out_last)
        else $error("bare marker without last");

endmodule
